/* rtl/f2h_pkg.sv */
// Package with shared constants and helper types for the binary32 to binary16 converter.
`timescale 1ns / 1ps
`default_nettype none
package f2h_pkg;
  localparam logic [30:0] HALF_MAX_MAG = 31'h477FE000;
  localparam logic [30:0] INF_MAG = 31'h7F800000;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_HALF_OVF = 8'd143;
  localparam logic [7:0] EXP_HALF_NORM = 8'd113;
  localparam logic [14:0] HALF_INF = 15'h7C00;
  localparam logic [14:0] HALF_QNAN = 15'h7E00;

  typedef struct packed {
    logic [15:0] half_bits;
    logic        ovf_hit;
  } conv_res_t;
endpackage
`default_nettype wire

/* rtl/f2h_convert.sv */
// Combinational binary32 to binary16 conversion with round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module f2h_convert (
  input  wire logic [31:0]         value_bits,
  output f2h_pkg::conv_res_t       res
);
  logic        sgn;
  logic [7:0]  e;
  logic [22:0] m;
  logic [30:0] mag;
  logic [14:0] r;
  logic [12:0] rem;
  logic [23:0] full;
  logic [7:0]  shift;
  logic [4:0]  sh;
  logic [23:0] q;
  logic [23:0] remd;
  logic [23:0] halfway;
  logic [23:0] rmask;

  always_comb begin
    sgn = value_bits[31];
    e = value_bits[30:23];
    m = value_bits[22:0];
    mag = value_bits[30:0];
    full = {1'b1, m};
    shift = 8'd126 - e;
    sh = shift[4:0];
    q = full >> sh;
    rmask = (24'd1 << sh) - 24'd1;
    remd = full & rmask;
    halfway = 24'd1 << (sh - 5'd1);
    r = '0;
    rem = '0;
    if (e == f2h_pkg::EXP_ALL_ONES) begin
      if (m == '0) r = f2h_pkg::HALF_INF;
      else r = f2h_pkg::HALF_QNAN | {5'd0, m[22:13]};
    end else if (e >= f2h_pkg::EXP_HALF_OVF) begin
      r = f2h_pkg::HALF_INF;
    end else if (e >= f2h_pkg::EXP_HALF_NORM) begin
      r = {5'(e - 8'd112), m[22:13]};
      rem = m[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && r[0])) r = r + 15'd1;
    end else if (e == '0 || shift > 8'd24) begin
      r = '0;
    end else begin
      // Subnormal result: shift the full mantissa right and round.
      r = q[14:0];
      if (remd > halfway || (remd == halfway && q[0])) r = r + 15'd1;
    end
    res.half_bits = {sgn, r};
    res.ovf_hit = (mag > f2h_pkg::HALF_MAX_MAG) && (mag <= f2h_pkg::INF_MAG);
  end
endmodule
`default_nettype wire

/* rtl/float32_to_half_with_overflow_flag_unit.sv */
// Top level of the binary32 to binary16 converter with sticky overflow flag.
// The unit converts one binary32 pattern per transfer to binary16 with round
// to nearest even, producing subnormals, signed infinities on overflow and
// quiet NaNs. It accepts one item every cycle while out_stall is low: an
// input register feeds a single stage of conversion logic that writes a
// result register, and a skid register lets the input side keep taking a
// transfer while a finished result waits. An input transfer is held in the
// input register, and its converted result is loaded into the result
// register when that register is free or being read, which raises out_valid.
// Stalls only come from out_stall; without them a new transfer is
// taken every cycle.
// The overflow flag is cleared by a first mark, set by any finite or
// infinite magnitude above 65504, never by a NaN, and goes out with each
// result.
`timescale 1ns / 1ps
`default_nettype none
module float32_to_half_with_overflow_flag_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_value_bits,
  input  wire logic        in_first_element,
  input  wire logic        in_last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_half_bits,
  output logic             out_overflow_seen,
  output logic             out_last_result
);
  // Input register stage.
  logic        a_vld_r;
  logic [31:0] a_val_r;
  logic        a_first_r, a_last_r;
  // Skid register holding an input transfer taken while stage a was blocked.
  logic        s_vld_r;
  logic [31:0] s_val_r;
  logic        s_first_r, s_last_r;
  // Result register.
  logic        o_vld_r;
  logic [15:0] o_half_r;
  logic        o_flag_r, o_last_r;
  logic        sticky_r;
  logic        flag_nxt;
  logic        o_adv, a_adv;
  f2h_pkg::conv_res_t conv;

  f2h_convert u_conv (.value_bits(a_val_r), .res(conv));

  assign o_adv = a_vld_r && (!o_vld_r || !out_stall);
  // Stage a can load when empty or moving on this cycle.
  assign a_adv = !a_vld_r || o_adv;
  assign in_stall = s_vld_r;
  assign flag_nxt = conv.ovf_hit | (a_first_r ? 1'b0 : sticky_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      sticky_r <= 1'b0;
    end else begin
      if (o_adv) begin
        o_vld_r <= 1'b1;
        sticky_r <= flag_nxt;
      end else if (!out_stall) begin
        o_vld_r <= 1'b0;
      end
      if (a_adv) begin
        if (s_vld_r) begin
          a_vld_r <= 1'b1;
          s_vld_r <= 1'b0;
        end else begin
          a_vld_r <= in_valid;
        end
      end else if (in_valid && !s_vld_r) begin
        s_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      o_half_r <= conv.half_bits;
      o_flag_r <= flag_nxt;
      o_last_r <= a_last_r;
    end
    if (a_adv) begin
      if (s_vld_r) begin
        a_val_r <= s_val_r;
        a_first_r <= s_first_r;
        a_last_r <= s_last_r;
      end else begin
        a_val_r <= in_value_bits;
        a_first_r <= in_first_element;
        a_last_r <= in_last_element;
      end
    end else if (!s_vld_r) begin
      s_val_r <= in_value_bits;
      s_first_r <= in_first_element;
      s_last_r <= in_last_element;
    end
  end

  assign out_valid = o_vld_r;
  assign out_half_bits = o_half_r;
  assign out_overflow_seen = o_flag_r;
  assign out_last_result = o_last_r;
endmodule
`default_nettype wire
